// ----- design/rprc_pkg.sv -----
// ----------------------------------------------------------------------------
// rprc_pkg
// Types, constants and the crc-8 byte update for the pak responder.
// ----------------------------------------------------------------------------
package rprc_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
    localparam int NUM_PORTS = 4;

    localparam logic [7:0]  CRC_POLY   = 8'h85;
    localparam logic [15:0] ADDR_MASK  = 16'hFFE0;
    localparam logic [15:0] FILL_LOW   = 16'h8000;
    localparam logic [15:0] FILL_HIGH  = 16'h9000;
    localparam logic [7:0]  FILL_BYTE  = 8'h80;
    localparam logic [15:0] RUMBLE_RST = 16'hC000;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic CFG_RAW_MODE_MASK  = 1'b0;
    localparam logic CFG_RUMBLE_ADDRESS = 1'b1;

    localparam logic [CNT_W-1:0] BLOCK_CNT = CNT_W'(BLOCK_BYTES);

    typedef struct packed {
        logic        req_type;
        logic [1:0]  port;
        logic [15:0] address;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_crc;
        logic        last;
        logic [1:0]  out_port;
        logic [3:0]  rumble_flags;
    } rsp_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/rumble_pak_responder_crc8.sv -----
// ----------------------------------------------------------------------------
// rumble_pak_responder_crc8
// Accessory-pak responder with rumble control and crc-8 over 32-byte blocks.
// ----------------------------------------------------------------------------
// a request is held in the input register, its result in the result register
// throughput, when the result register is not stalled: writes one per cycle;
//   a raw read holds the input register, one fill or crc byte per cycle
// reset: config registers, crc, byte count and rumble bits return to reset
module rumble_pak_responder_crc8
    import rprc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic                  in_valid_reg, in_valid_next;
    req_t                  in_item_reg, in_item_next;
    logic [CNT_W-1:0]      beat_reg, beat_next;
    logic [7:0]            read_crc_reg, read_crc_next;
    logic [3:0]            raw_mask_reg, raw_mask_next;
    logic [15:0]           rumble_addr_reg, rumble_addr_next;
    logic [7:0]            run_crc_reg, run_crc_next;
    logic [CNT_W-1:0]      wr_count_reg, wr_count_next;
    logic [3:0]            rumble_reg, rumble_next;
    logic                  res_valid_reg, res_valid_next;
    rsp_t                  res_data_reg, res_data_next;

    logic                  advance;
    logic                  raw;
    logic                  is_read;
    logic                  done;
    logic [15:0]           addr_m;
    logic [7:0]            fill;
    logic [7:0]            wr_crc;
    logic [CNT_W-1:0]      wr_count_inc;

    assign cfg_ready = 1'b1;
    assign rsp_valid = res_valid_reg;
    assign rsp_data  = res_data_reg;

    assign advance = in_valid_reg && (!res_valid_reg || rsp_ready);
    assign raw     = raw_mask_reg[in_item_reg.port];
    assign is_read = (in_item_reg.req_type == REQ_READ);
    assign done    = !raw || !is_read || (beat_reg == BLOCK_CNT);
    assign req_ready = !in_valid_reg || (advance && done);

    assign addr_m = in_item_reg.address & ADDR_MASK;
    assign fill   = (addr_m >= FILL_LOW && addr_m < FILL_HIGH) ? FILL_BYTE : 8'h00;

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        in_item_next     = in_item_reg;
        beat_next        = beat_reg;
        read_crc_next    = read_crc_reg;
        raw_mask_next    = raw_mask_reg;
        rumble_addr_next = rumble_addr_reg;
        run_crc_next     = run_crc_reg;
        wr_count_next    = wr_count_reg;
        rumble_next      = rumble_reg;
        res_valid_next   = res_valid_reg;
        res_data_next    = res_data_reg;
        wr_crc           = 8'h00;
        wr_count_inc     = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAW_MODE_MASK:  raw_mask_next = cfg_data[3:0];
                CFG_RUMBLE_ADDRESS: rumble_addr_next = cfg_data;
                default:            raw_mask_next = raw_mask_reg;
            endcase
        end

        if (rsp_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (advance && raw)
        begin
            if (is_read)
            begin
                run_crc_next  = 8'h00;
                wr_count_next = '0;
                res_valid_next = 1'b1;
                res_data_next.out_port     = in_item_reg.port;
                res_data_next.rumble_flags = rumble_reg;
                if (beat_reg == BLOCK_CNT)
                begin
                    res_data_next.out_byte = read_crc_reg;
                    res_data_next.is_crc   = 1'b1;
                    res_data_next.last     = 1'b1;
                    beat_next              = '0;
                    read_crc_next          = 8'h00;
                end
                else
                begin
                    res_data_next.out_byte = fill;
                    res_data_next.is_crc   = 1'b0;
                    res_data_next.last     = 1'b0;
                    beat_next              = beat_reg + 1'b1;
                    read_crc_next          = crc_byte(read_crc_reg, fill);
                end
            end
            else
            begin
                // first byte of a run may switch rumble
                if (wr_count_reg == '0)
                begin
                    if (addr_m == (rumble_addr_reg & ADDR_MASK))
                    begin
                        rumble_next[in_item_reg.port] = (in_item_reg.data_byte != 8'h00);
                    end
                    wr_crc = crc_byte(8'h00, in_item_reg.data_byte);
                end
                else
                begin
                    wr_crc = crc_byte(run_crc_reg, in_item_reg.data_byte);
                end
                wr_count_inc = wr_count_reg + 1'b1;
                if (wr_count_inc >= BLOCK_CNT)
                begin
                    wr_count_next  = '0;
                    run_crc_next   = 8'h00;
                    res_valid_next = 1'b1;
                    res_data_next.out_byte     = wr_crc;
                    res_data_next.is_crc       = 1'b1;
                    res_data_next.last         = 1'b1;
                    res_data_next.out_port     = in_item_reg.port;
                    res_data_next.rumble_flags = rumble_next;
                end
                else
                begin
                    wr_count_next = wr_count_inc;
                    run_crc_next  = wr_crc;
                end
            end
        end

        if (advance && done)
        begin
            in_valid_next = 1'b0;
        end

        if (req_valid && req_ready)
        begin
            in_valid_next = 1'b1;
            in_item_next  = req_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            beat_reg        <= '0;
            read_crc_reg    <= 8'h00;
            raw_mask_reg    <= 4'h0;
            rumble_addr_reg <= RUMBLE_RST;
            run_crc_reg     <= 8'h00;
            wr_count_reg    <= '0;
            rumble_reg      <= 4'h0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            beat_reg        <= beat_next;
            read_crc_reg    <= read_crc_next;
            raw_mask_reg    <= raw_mask_next;
            rumble_addr_reg <= rumble_addr_next;
            run_crc_reg     <= run_crc_next;
            wr_count_reg    <= wr_count_next;
            rumble_reg      <= rumble_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        res_data_reg <= res_data_next;
    end

    // read beat never runs past the crc byte
    assert property (@(posedge clk) disable iff (!rst_n) beat_reg <= BLOCK_CNT)
        else $error("read beat counter out of range");

    // no new request while the fill bytes of a read block are being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != '0 && beat_reg != BLOCK_CNT) |-> !req_ready)
        else $error("request taken during read block");

    // last result is always the crc
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.last) |-> rsp_data.is_crc)
        else $error("last without crc");

    // fill bytes are only the two fill values
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.is_crc) |->
        (rsp_data.out_byte == FILL_BYTE || rsp_data.out_byte == 8'h00))
        else $error("bad fill byte");

    // write byte count stays below a full block
    assert property (@(posedge clk) disable iff (!rst_n) wr_count_reg < BLOCK_CNT)
        else $error("write byte count out of range");

endmodule
